// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the triggered capture averager RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TCA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TCA_ASSERT(lbl, clk, rst_n, prop, msg)
`define TCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/tca_pkg.sv -----
// Types, codes and constants of the triggered capture averager.
package tca_pkg;

    localparam int MAX_CAPTURE = 2048;
    localparam int SAMPLE_BITS = 12;
    localparam int ADDR_W      = $clog2(MAX_CAPTURE);
    localparam int LEN_W       = ADDR_W + 1;
    localparam int PRE_W       = 11;
    localparam int SUM_W       = 20;
    localparam int CNT_W       = 8;
    localparam int BIN_W       = SUM_W + CNT_W;
    localparam int AVG_W       = 12;
    localparam int KIND_W      = 2;
    localparam int PADDR_W     = 4;
    localparam int APB_W       = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [KIND_W-1:0] RPL_CAPTURE = 2'd0;
    localparam logic [KIND_W-1:0] RPL_READ    = 2'd1;
    localparam logic [KIND_W-1:0] RPL_CLEAR   = 2'd2;

    localparam logic [1:0] REG_LEVEL  = 2'd0;
    localparam logic [1:0] REG_HYST   = 2'd1;
    localparam logic [1:0] REG_PRE    = 2'd2;
    localparam logic [1:0] REG_LENGTH = 2'd3;

    localparam logic [SAMPLE_BITS-1:0] LEVEL_RST  = 12'd1200;
    localparam logic [SAMPLE_BITS-1:0] HYST_RST   = 12'd20;
    localparam logic [PRE_W-1:0]       PRE_RST    = 11'd400;
    localparam logic [LEN_W-1:0]       LENGTH_RST = 12'd2000;

    typedef struct packed {
        logic [1:0]             action;
        logic [SAMPLE_BITS-1:0] sample_value;
        logic [ADDR_W-1:0]      bin_index;
    } t_tca_in;

    typedef struct packed {
        logic [KIND_W-1:0] reply_kind;
        logic              trigger_found;
        logic [ADDR_W-1:0] trigger_position;
        logic [SUM_W-1:0]  bin_sum;
        logic [CNT_W-1:0]  bin_count;
        logic [AVG_W-1:0]  bin_average;
        logic              bin_empty;
    } t_tca_out;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_ACCUM,
        S_READ,
        S_DIV
    } t_state;

endpackage

// ----- hw/rtl/tca_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/tca_div.sv -----
// Restoring divider, one quotient bit per cycle, for bin averages.
module tca_div
    import tca_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output logic             o_done,
    output logic [SUM_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic [SUM_W-1:0]  r_quo, n_quo;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [CNT_W-1:0]  r_dvs, n_dvs;
    logic [CNT_W:0]    rem_sh;
    logic              q_bit;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        rem_sh = {r_rem, r_quo[SUM_W-1]};
        q_bit  = (rem_sh >= {1'b0, r_dvs});
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[SUM_W-2:0], q_bit};
            n_rem = q_bit ? CNT_W'(rem_sh - {1'b0, r_dvs}) : rem_sh[CNT_W-1:0];
            n_step = r_step + STEP_W'(1);
            if (r_step == STEP_W'(SUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_step <= n_step;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- hw/rtl/triggered_capture_averager.sv -----
// Triggered capture averager: capture store, trigger scan, bin accumulation and bin reads.
// Load that does not finish a capture: the next request is taken in the following cycle.
// Finishing load: a trigger scan over the capture, then accumulation into the bins if a trigger is found.
// Bin read: an empty bin replies straight from the read, else the divider runs (one quotient bit per cycle).
// Clear: one bin per cycle; reset runs the same sweep with busy high.
// Results are strobed for one cycle; configuration writes are taken at any time.
`include "assert_macros.svh"

module triggered_capture_averager
    import tca_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_tca_in            i_req,
    output logic               o_strobe,
    output t_tca_out           o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]   pwdata,
    output logic [APB_W-1:0]   prdata,
    output logic               pready
);

    t_state                 r_state, n_state;
    logic [LEN_W-1:0]       r_fill, n_fill;
    logic [LEN_W-1:0]       r_ptr, n_ptr;
    logic [LEN_W-1:0]       r_bin, n_bin;
    logic [LEN_W-1:0]       r_pidx, n_pidx;
    logic                   r_pvld, n_pvld;
    logic                   r_armed, n_armed;
    logic [ADDR_W-1:0]      r_trig_pos, n_trig_pos;
    logic [ADDR_W-1:0]      r_clr_addr, n_clr_addr;
    logic                   r_clr_reply, n_clr_reply;
    logic [SUM_W-1:0]       r_rd_sum, n_rd_sum;
    logic [CNT_W-1:0]       r_rd_cnt, n_rd_cnt;
    logic                   r_strobe, n_strobe;
    t_tca_out               r_rsp, n_rsp;
    logic                   r_div_go;

    logic [SAMPLE_BITS-1:0] r_level;
    logic [SAMPLE_BITS-1:0] r_hyst;
    logic [PRE_W-1:0]       r_pre;
    logic [LEN_W-1:0]       r_len;

    logic [LEN_W-1:0]       eff_len;
    logic [LEN_W-1:0]       fp;
    logic [LEN_W-1:0]       fp_inc;
    logic                   issue;
    logic                   trig;
    logic                   pidx_gt;
    logic [LEN_W-1:0]       acc_i0;
    logic [LEN_W-1:0]       acc_b0;
    logic [SUM_W-1:0]       rd_sum;
    logic [CNT_W-1:0]       rd_cnt;

    logic                   cap_we;
    logic [ADDR_W-1:0]      cap_waddr;
    logic [SAMPLE_BITS-1:0] cap_wdata;
    logic [ADDR_W-1:0]      cap_raddr;
    logic [SAMPLE_BITS-1:0] cap_rdata;
    logic                   bin_we;
    logic [ADDR_W-1:0]      bin_waddr;
    logic [BIN_W-1:0]       bin_wdata;
    logic [ADDR_W-1:0]      bin_raddr;
    logic [BIN_W-1:0]       bin_rdata;
    logic                   div_start;
    logic                   div_done;
    logic [SUM_W-1:0]       div_quo;
    logic                   cfg_wr;

    tca_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_CAPTURE)
    ) u_cap_ram (
        .i_clk   (i_clk),
        .i_we    (cap_we),
        .i_waddr (cap_waddr),
        .i_wdata (cap_wdata),
        .i_raddr (cap_raddr),
        .o_rdata (cap_rdata)
    );

    tca_ram #(
        .WIDTH (BIN_W),
        .DEPTH (MAX_CAPTURE)
    ) u_bin_ram (
        .i_clk   (i_clk),
        .i_we    (bin_we),
        .i_waddr (bin_waddr),
        .i_wdata (bin_wdata),
        .i_raddr (bin_raddr),
        .o_rdata (bin_rdata)
    );

    tca_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_rd_sum),
        .i_divisor  (r_rd_cnt),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= LEVEL_RST;
            r_hyst  <= HYST_RST;
            r_pre   <= PRE_RST;
            r_len   <= LENGTH_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_LEVEL:  r_level <= pwdata[SAMPLE_BITS-1:0];
                REG_HYST:   r_hyst  <= pwdata[SAMPLE_BITS-1:0];
                REG_PRE:    r_pre   <= pwdata[PRE_W-1:0];
                REG_LENGTH: r_len   <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_LEVEL:  prdata = APB_W'(r_level);
            REG_HYST:   prdata = APB_W'(r_hyst);
            REG_PRE:    prdata = APB_W'(r_pre);
            REG_LENGTH: prdata = APB_W'(r_len);
            default:    prdata = '0;
        endcase
    end

    // Datapath helpers
    always_comb begin
        if (r_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_len > LEN_W'(MAX_CAPTURE)) begin
            eff_len = LEN_W'(MAX_CAPTURE);
        end else begin
            eff_len = r_len;
        end
    end

    assign fp      = (r_fill >= eff_len) ? '0 : r_fill;
    assign fp_inc  = fp + LEN_W'(1);
    assign pidx_gt = (r_pidx > LEN_W'(r_pre));
    assign acc_i0  = pidx_gt ? (r_pidx - LEN_W'(r_pre)) : '0;
    assign acc_b0  = pidx_gt ? '0 : (LEN_W'(r_pre) - r_pidx);
    assign rd_sum  = bin_rdata[BIN_W-1:CNT_W];
    assign rd_cnt  = bin_rdata[CNT_W-1:0];

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_ptr       = r_ptr;
        n_bin       = r_bin;
        n_pidx      = r_pidx;
        n_pvld      = r_pvld;
        n_armed     = r_armed;
        n_trig_pos  = r_trig_pos;
        n_clr_addr  = r_clr_addr;
        n_clr_reply = r_clr_reply;
        n_rd_sum    = r_rd_sum;
        n_rd_cnt    = r_rd_cnt;
        n_strobe    = 1'b0;
        n_rsp       = '0;
        cap_we      = 1'b0;
        cap_waddr   = fp[ADDR_W-1:0];
        cap_wdata   = i_req.sample_value;
        cap_raddr   = r_ptr[ADDR_W-1:0];
        bin_we      = 1'b0;
        bin_waddr   = r_pidx[ADDR_W-1:0];
        bin_wdata   = {SUM_W'(rd_sum + SUM_W'(cap_rdata)), CNT_W'(rd_cnt + CNT_W'(1))};
        bin_raddr   = r_bin[ADDR_W-1:0];
        div_start   = 1'b0;
        issue       = 1'b0;
        trig        = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                bin_we     = 1'b1;
                bin_waddr  = r_clr_addr;
                bin_wdata  = '0;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(MAX_CAPTURE - 1)) begin
                    n_state = S_IDLE;
                    if (r_clr_reply) begin
                        n_strobe         = 1'b1;
                        n_rsp.reply_kind = RPL_CLEAR;
                    end
                end
            end
            S_IDLE: begin
                if (start) begin
                    case (i_req.action)
                        ACT_LOAD: begin
                            cap_we = 1'b1;
                            if (fp_inc < eff_len) begin
                                n_fill = fp_inc;
                            end else begin
                                n_fill  = '0;
                                n_ptr   = '0;
                                n_pvld  = 1'b0;
                                n_state = S_SCAN;
                            end
                        end
                        ACT_READ: begin
                            bin_raddr = i_req.bin_index;
                            n_state   = S_READ;
                        end
                        ACT_CLEAR: begin
                            n_clr_addr  = '0;
                            n_clr_reply = 1'b1;
                            n_state     = S_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                issue  = (r_ptr < eff_len);
                n_pvld = issue;
                n_pidx = r_ptr;
                if (issue) begin
                    n_ptr = r_ptr + LEN_W'(1);
                end
                if (r_pvld) begin
                    trig = (r_pidx != '0) && r_armed && (cap_rdata >= r_level);
                    if (trig) begin
                        n_trig_pos = r_pidx[ADDR_W-1:0];
                        n_ptr      = acc_i0;
                        n_bin      = acc_b0;
                        n_pvld     = 1'b0;
                        n_state    = S_ACCUM;
                    end else begin
                        if (r_pidx == '0) begin
                            n_armed = (cap_rdata < r_level);
                        end else if (({1'b0, cap_rdata} + {1'b0, r_hyst}) < {1'b0, r_level})
                        begin
                            n_armed = 1'b1;
                        end
                        if (r_pidx == eff_len - LEN_W'(1)) begin
                            n_pvld           = 1'b0;
                            n_strobe         = 1'b1;
                            n_rsp.reply_kind = RPL_CAPTURE;
                            n_state          = S_IDLE;
                        end
                    end
                end
            end
            S_ACCUM: begin
                issue  = (r_ptr < eff_len) && (r_bin < eff_len);
                n_pvld = issue;
                n_pidx = r_bin;
                if (issue) begin
                    n_ptr = r_ptr + LEN_W'(1);
                    n_bin = r_bin + LEN_W'(1);
                end
                if (r_pvld) begin
                    bin_we = (rd_cnt != CNT_MAX);
                end else if (!issue) begin
                    n_strobe               = 1'b1;
                    n_rsp.reply_kind       = RPL_CAPTURE;
                    n_rsp.trigger_found    = 1'b1;
                    n_rsp.trigger_position = r_trig_pos;
                    n_state                = S_IDLE;
                end
            end
            S_READ: begin
                n_rd_sum = rd_sum;
                n_rd_cnt = rd_cnt;
                if (rd_cnt == '0) begin
                    n_strobe         = 1'b1;
                    n_rsp.reply_kind = RPL_READ;
                    n_rsp.bin_sum    = rd_sum;
                    n_rsp.bin_empty  = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                div_start = r_div_go;
                if (div_done) begin
                    n_strobe          = 1'b1;
                    n_rsp.reply_kind  = RPL_READ;
                    n_rsp.bin_sum     = r_rd_sum;
                    n_rsp.bin_count   = r_rd_cnt;
                    n_rsp.bin_average = div_quo[AVG_W-1:0];
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Launch the divider in the cycle after the bin data is latched
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_go <= 1'b0;
        end else begin
            r_div_go <= (r_state == S_READ) && (rd_cnt != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_fill      <= '0;
            r_pvld      <= 1'b0;
            r_clr_addr  <= '0;
            r_clr_reply <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_pvld      <= n_pvld;
            r_clr_addr  <= n_clr_addr;
            r_clr_reply <= n_clr_reply;
            r_strobe    <= n_strobe;
        end
        r_ptr      <= n_ptr;
        r_bin      <= n_bin;
        r_pidx     <= n_pidx;
        r_armed    <= n_armed;
        r_trig_pos <= n_trig_pos;
        r_rd_sum   <= n_rd_sum;
        r_rd_cnt   <= n_rd_cnt;
        r_rsp      <= n_rsp;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

    `TCA_ASSERT(a_strobe_after_busy, i_clk, i_rst_n, o_strobe |-> $past(busy), "result without request in flight")
    `TCA_ASSERT(a_clear_reply_src, i_clk, i_rst_n, (o_strobe && o_rsp.reply_kind == RPL_CLEAR) |-> ($past(r_state) == S_CLEAR), "clear reply outside clear sweep")
    `TCA_ASSERT_NEXT(a_clear_enters_sweep, i_clk, i_rst_n, start && !busy && i_req.action == ACT_CLEAR, r_state == S_CLEAR, "clear request did not start sweep")
    `TCA_ASSERT(a_fill_range, i_clk, i_rst_n, r_fill < LEN_W'(MAX_CAPTURE), "fill position out of range")

endmodule
